// ===== design/cordic_sine_cosine_assert.svh =====
// Assertion macros used by the CORDIC micro-rotation stage design file.
`ifndef CORDIC_SINE_COSINE_ASSERT_SVH
`define CORDIC_SINE_COSINE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define CSC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define CSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/csc_pkg.sv =====
// Shared widths, constants and types of the CORDIC sine and cosine pipeline.
`timescale 1ns / 1ps

package csc_pkg;

	// Field and datapath widths
	localparam int ANGLE_W  = 18;
	localparam int WORD_W   = 16;
	localparam int WRAP_W   = ANGLE_W + 1;
	localparam int MAX_ITER = 16;
	localparam int STEP_W   = $clog2(MAX_ITER);

	// Angle constants at 14 fraction bits
	localparam logic signed [WRAP_W-1:0] ANG_PI      = 19'sd51471;
	localparam logic signed [WRAP_W-1:0] ANG_TWO_PI  = 19'sd102943;
	localparam logic signed [WRAP_W-1:0] ANG_HALF_PI = 19'sd25735;
	localparam logic signed [WORD_W-1:0] INV_GAIN    = 16'sd9949;

	// Arctangent of 2^-k at 14 fraction bits
	localparam logic signed [WORD_W-1:0] ATAN_TAB [MAX_ITER] = '{
		16'sh3243, 16'sh1DAC, 16'sh0FAD, 16'sh07F5,
		16'sh03FE, 16'sh01FF, 16'sh00FF, 16'sh007F,
		16'sh003F, 16'sh001F, 16'sh000F, 16'sh0007,
		16'sh0003, 16'sh0001, 16'sh0000, 16'sh0000
	};

	// Vector and residual angle carried down the pipeline
	typedef struct packed {
		logic signed [WORD_W-1:0] x;
		logic signed [WORD_W-1:0] y;
		logic signed [WORD_W-1:0] z;
	} csc_vec_t;

endpackage

// ===== design/csc_angle_if.sv =====
// Input channel carrying one angle item.
`timescale 1ns / 1ps

interface csc_angle_if;
	import csc_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [ANGLE_W-1:0] angle;

	modport source (output valid, output angle, input ready);
	modport sink   (input valid, input angle, output ready);
endinterface

// ===== design/csc_result_if.sv =====
// Output channel carrying one sine and cosine item.
`timescale 1ns / 1ps

interface csc_result_if;
	import csc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] sine;
	logic signed [WORD_W-1:0] cosine;

	modport source (output valid, output sine, output cosine, input ready);
	modport sink   (input valid, input sine, input cosine, output ready);
endinterface

// ===== design/csc_stage.sv =====
// One CORDIC micro-rotation followed by its pipeline register.
`timescale 1ns / 1ps
`include "cordic_sine_cosine_assert.svh"

module csc_stage #(
	parameter int STEP = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  csc_pkg::csc_vec_t  in_vec,
	output logic               out_valid,
	input  logic               out_ready,
	output csc_pkg::csc_vec_t  out_vec
);
	import csc_pkg::*;

	localparam logic [STEP_W-1:0] STEP_IDX = STEP_W'(STEP);

	logic                     valid_s1;
	csc_vec_t                 vec_s1;
	csc_vec_t                 rot;
	logic signed [WORD_W-1:0] xs;
	logic signed [WORD_W-1:0] ys;

	// Rotate towards zero residual angle
	always_comb begin
		xs = in_vec.x >>> STEP;
		ys = in_vec.y >>> STEP;
		if (!in_vec.z[WORD_W-1]) begin
			rot.x = in_vec.x - ys;
			rot.y = in_vec.y + xs;
			rot.z = in_vec.z - ATAN_TAB[STEP_IDX];
		end else begin
			rot.x = in_vec.x + ys;
			rot.y = in_vec.y - xs;
			rot.z = in_vec.z + ATAN_TAB[STEP_IDX];
		end
	end

	// Take a new item when empty or when the held one leaves
	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			vec_s1 <= rot;
		end
	end

	assign out_valid = valid_s1;
	assign out_vec   = vec_s1;

	`CSC_ASSERT_NEXT(a_hold_on_stall, valid_s1 && !out_ready,
		valid_s1 && $stable(vec_s1), "stalled item changed or was lost")
	`CSC_ASSERT_NOW(a_ready_when_empty, !valid_s1, in_ready,
		"empty stage refused an item")
	`CSC_ASSERT_NEXT(a_take_item, in_valid && in_ready, valid_s1,
		"accepted item did not reach the stage register")
endmodule

// ===== design/cordic_sine_cosine.sv =====
// Top level of the pipelined CORDIC sine and cosine generator.
// Takes one signed angle in radians (14 fraction bits) per cycle and returns
// its sine and cosine (16 bits signed, 14 fraction bits). One register stage
// reduces the angle into minus half pi to half pi, then ITERATIONS stages
// each perform one micro-rotation and register it; throughput is one item
// per cycle when the result side is ready. A stall on the result side holds
// every full stage; empty stages still fill behind it.
`timescale 1ns / 1ps

module cordic_sine_cosine #(
	parameter int ITERATIONS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	csc_angle_if.sink     angles,
	csc_result_if.source  results
);
	import csc_pkg::*;

	logic                     link_valid [ITERATIONS+1];
	logic                     link_ready [ITERATIONS+1];
	csc_vec_t                 link_vec   [ITERATIONS+1];

	logic signed [WRAP_W-1:0] ang_ext;
	logic signed [WRAP_W-1:0] ang_wrap;
	logic signed [WRAP_W-1:0] ang_fold;
	logic                     flip;
	csc_vec_t                 start;
	logic                     valid_s1;
	csc_vec_t                 vec_s1;

	// Wrap once into minus pi to pi, then fold beyond half pi
	always_comb begin
		ang_ext = WRAP_W'(angles.angle);
		if (ang_ext > ANG_PI) begin
			ang_wrap = ang_ext - ANG_TWO_PI;
		end else if (ang_ext < -ANG_PI) begin
			ang_wrap = ang_ext + ANG_TWO_PI;
		end else begin
			ang_wrap = ang_ext;
		end
		flip = 1'b1;
		if (ang_wrap > ANG_HALF_PI) begin
			ang_fold = ang_wrap - ANG_PI;
		end else if (ang_wrap < -ANG_HALF_PI) begin
			ang_fold = ang_wrap + ANG_PI;
		end else begin
			ang_fold = ang_wrap;
			flip     = 1'b0;
		end
		start.x = flip ? -INV_GAIN : INV_GAIN;
		start.y = '0;
		start.z = ang_fold[WORD_W-1:0];
	end

	// Range reduction register
	assign angles.ready = !valid_s1 || link_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (angles.ready) begin
			valid_s1 <= angles.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (angles.ready && angles.valid) begin
			vec_s1 <= start;
		end
	end

	assign link_valid[0] = valid_s1;
	assign link_vec[0]   = vec_s1;

	// Chain of micro-rotation stages
	for (genvar k = 0; k < ITERATIONS; k++) begin : g_rot
		csc_stage #(
			.STEP (k)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (link_valid[k]),
			.in_ready  (link_ready[k]),
			.in_vec    (link_vec[k]),
			.out_valid (link_valid[k+1]),
			.out_ready (link_ready[k+1]),
			.out_vec   (link_vec[k+1])
		);
	end

	// Last stage register drives the result channel
	assign link_ready[ITERATIONS] = results.ready;
	assign results.valid  = link_valid[ITERATIONS];
	assign results.sine   = link_vec[ITERATIONS].y;
	assign results.cosine = link_vec[ITERATIONS].x;
endmodule
